>>> design/regex_literal_escape_encoder_top_macros.svh
// Assertion macros shared by the regex literal escape encoder RTL.
// Included by rlee_back, the module that carries the concurrent checks; depends on nothing.
`ifndef REGEX_LITERAL_ESCAPE_ENCODER_TOP_MACROS_SVH
`define REGEX_LITERAL_ESCAPE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLEE_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rlee: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLEE_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rlee: next-cycle check failed");

`endif

>>> design/rlee_pkg.sv
// Package for the regex literal escape encoder: shared types, codes and
// byte classification functions. Depends on nothing.
`default_nettype none

package rlee_pkg;

    // Length counter and configuration port sizes.
    localparam int LEN_W     = 32;
    localparam int SUM_W     = LEN_W + 1;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR_LEN = CFG_IDX_W'(1);

    // Queue sizes.
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = 1;
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = 2;

    // Characters used to build escapes.
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_U = 8'h75;

    // Byte classes for a byte that starts a new chunk.
    localparam logic [1:0] CLS_PLAIN  = 2'd0;
    localparam logic [1:0] CLS_SYNTAX = 2'd1;
    localparam logic [1:0] CLS_HEX    = 2'd2;
    localparam logic [1:0] CLS_CTRL   = 2'd3;

    // One classified input word: raw single-byte chunks, then one main chunk.
    typedef struct packed {
        logic [2:0][7:0] raw;
        logic [1:0]      raw_cnt;
        logic [5:0][7:0] main;
        logic [2:0]      main_len;
        logic            first;
        logic            fin;
    } job_t;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       no_data;
        logic       run_last;
        logic       string_done;
        logic       overflow;
    } result_t;

    function automatic logic [1:0] byte_class(input logic [7:0] c);
        logic [1:0] cls;
        unique case (c)
            8'h5E, 8'h24, 8'h5C, 8'h2E, 8'h2A, 8'h2B, 8'h3F, 8'h28,
            8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h2F:
                cls = CLS_SYNTAX;
            8'h2C, 8'h2D, 8'h3D, 8'h3C, 8'h3E, 8'h23, 8'h26, 8'h21, 8'h25,
            8'h3A, 8'h3B, 8'h40, 8'h7E, 8'h27, 8'h60, 8'h22, 8'h20:
                cls = CLS_HEX;
            8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B:
                cls = CLS_CTRL;
            default:
                cls = CLS_PLAIN;
        endcase
        return cls;
    endfunction

    // Letter that follows the backslash for a control character.
    function automatic logic [7:0] ctrl_letter(input logic [7:0] c);
        logic [7:0] l;
        unique case (c)
            8'h0C:   l = 8'h66;
            8'h0A:   l = 8'h6E;
            8'h0D:   l = 8'h72;
            8'h09:   l = 8'h74;
            8'h0B:   l = 8'h76;
            default: l = 8'h00;
        endcase
        return l;
    endfunction

    // Lower-case hex digit.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] h;
        if (n < 4'd10)
        begin
            h = 8'h30 + {4'h0, n};
        end
        else
        begin
            h = 8'h57 + {4'h0, n};
        end
        return h;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Total sequence length announced by a lead byte, zero if not a lead.
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] n;
        if (c >= 8'hC2 && c <= 8'hDF)
        begin
            n = 3'd2;
        end
        else if (c >= 8'hE0 && c <= 8'hEF)
        begin
            n = 3'd3;
        end
        else if (c >= 8'hF0 && c <= 8'hF4)
        begin
            n = 3'd4;
        end
        else
        begin
            n = 3'd0;
        end
        return n;
    endfunction

    // Continuation byte range check; the second byte has lead-specific limits.
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 2'd1)
        begin
            if (lead == 8'hE0)
            begin
                lo = 8'hA0;
            end
            else if (lead == 8'hF0)
            begin
                lo = 8'h90;
            end
            else if (lead == 8'hF4)
            begin
                hi = 8'h8F;
            end
        end
        return c >= lo && c <= hi;
    endfunction

    // ECMAScript whitespace and line terminators outside ASCII.
    function automatic logic is_space_cp(input logic [20:0] cp);
        return cp == 21'h0000A0 || cp == 21'h001680 ||
               (cp >= 21'h002000 && cp <= 21'h00200A) ||
               cp == 21'h002028 || cp == 21'h002029 || cp == 21'h00202F ||
               cp == 21'h00205F || cp == 21'h003000 || cp == 21'h00FEFF;
    endfunction

endpackage

`default_nettype wire

>>> design/rlee_job_queue.sv
// Two-entry queue of classified words between the front and the back.
// Depends on rlee_pkg for the job word type and queue sizes.
`default_nettype none

module rlee_job_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire rlee_pkg::job_t wr_job,
    output logic               q_full,
    input  wire logic          rd_en,
    output logic               q_valid,
    output rlee_pkg::job_t     rd_job
);
    import rlee_pkg::*;

    job_t                 entry_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]   wr_ptr_reg;
    logic [JOBQ_AW-1:0]   rd_ptr_reg;
    logic [JOBQ_AW:0]     count_reg;
    logic [JOBQ_AW:0]     count_next;

    assign q_full  = count_reg == (JOBQ_AW + 1)'(JOBQ_DEPTH);
    assign q_valid = count_reg != '0;
    assign rd_job  = entry_reg[rd_ptr_reg];

    // Occupancy follows the write and read strobes.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

>>> design/rlee_result_queue.sv
// Four-entry result queue that drives the output ports.
// Depends on rlee_pkg for the result word type and queue sizes.
`default_nettype none

module rlee_result_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire rlee_pkg::result_t wr_res,
    output logic                  q_full,
    input  wire logic             rd_en,
    output logic                  q_valid,
    output rlee_pkg::result_t     rd_res
);
    import rlee_pkg::*;

    result_t              entry_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0]   wr_ptr_reg;
    logic [RESQ_AW-1:0]   rd_ptr_reg;
    logic [RESQ_AW:0]     count_reg;
    logic [RESQ_AW:0]     count_next;

    assign q_full  = count_reg == (RESQ_AW + 1)'(RESQ_DEPTH);
    assign q_valid = count_reg != '0;
    assign rd_res  = entry_reg[rd_ptr_reg];

    // Occupancy follows the write and read strobes.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_res;
        end
    end

endmodule

`default_nettype wire

>>> design/rlee_front.sv
// Front end: takes input words, tracks the pending WTF-8 sequence and
// turns each byte into a job of chunks. Depends on rlee_pkg.
`default_nettype none

module rlee_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic       jobq_full,
    input  wire logic [7:0] in_byte,
    input  wire logic       first_byte,
    input  wire logic       final_byte,
    output logic            job_push,
    output rlee_pkg::job_t  job
);
    import rlee_pkg::*;

    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      pcnt_reg;
    logic [1:0]      pcnt_next;
    logic [2:0]      exp_reg;
    logic [2:0]      exp_next;

    logic [1:0]      pcnt_e;
    logic [2:0]      exp_e;
    logic            fresh;
    logic [20:0]     cp;
    logic [2:0]      lead_n;

    assign job_push = push && !jobq_full;

    // Classify the byte against the pending sequence.
    always_comb
    begin
        pcnt_e    = first_byte ? 2'd0 : pcnt_reg;
        exp_e     = first_byte ? 3'd0 : exp_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_e;
        exp_next  = exp_e;
        fresh     = 1'b0;
        cp        = '0;
        lead_n    = lead_len(in_byte);
        job       = '0;
        job.first = first_byte;
        job.fin   = final_byte;

        if (first_byte && is_alnum(in_byte))
        begin
            // A leading letter or digit is always written as a hex escape.
            job.main[0]  = CH_BSLASH;
            job.main[1]  = CH_LOWER_X;
            job.main[2]  = hex_char(in_byte[7:4]);
            job.main[3]  = hex_char(in_byte[3:0]);
            job.main_len = 3'd4;
        end
        else if (pcnt_e != 2'd0)
        begin
            if (cont_ok(pend_reg[0], pcnt_e, in_byte))
            begin
                if ({1'b0, pcnt_e} + 3'd1 == exp_e)
                begin
                    // Sequence complete: assemble the code point.
                    unique case (exp_e)
                        3'd2:
                            cp = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
                        3'd3:
                            cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]};
                        default:
                            cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                                  in_byte[5:0]};
                    endcase
                    pcnt_next = 2'd0;
                    exp_next  = 3'd0;
                    if (is_space_cp(cp) || (cp >= 21'h00D800 && cp <= 21'h00DFFF))
                    begin
                        job.main[0] = CH_BSLASH;
                        if (cp <= 21'h0000FF)
                        begin
                            job.main[1]  = CH_LOWER_X;
                            job.main[2]  = hex_char(cp[7:4]);
                            job.main[3]  = hex_char(cp[3:0]);
                            job.main_len = 3'd4;
                        end
                        else
                        begin
                            job.main[1]  = CH_LOWER_U;
                            job.main[2]  = hex_char(cp[15:12]);
                            job.main[3]  = hex_char(cp[11:8]);
                            job.main[4]  = hex_char(cp[7:4]);
                            job.main[5]  = hex_char(cp[3:0]);
                            job.main_len = 3'd6;
                        end
                    end
                    else
                    begin
                        // Pass the sequence through unchanged.
                        job.main[0]           = pend_reg[0];
                        job.main[1]           = pend_reg[1];
                        job.main[2]           = pend_reg[2];
                        job.main[exp_e - 3'd1] = in_byte;
                        job.main_len          = exp_e;
                    end
                end
                else
                begin
                    // Store the continuation byte; a final byte flushes all raw.
                    pend_next[pcnt_e] = in_byte;
                    pcnt_next         = pcnt_e + 2'd1;
                    if (final_byte)
                    begin
                        job.raw     = pend_next;
                        job.raw_cnt = pcnt_e + 2'd1;
                    end
                end
            end
            else
            begin
                // Broken sequence: stored bytes go out raw, then a fresh start.
                job.raw     = pend_reg;
                job.raw_cnt = pcnt_e;
                pcnt_next   = 2'd0;
                exp_next    = 3'd0;
                fresh       = 1'b1;
            end
        end
        else
        begin
            pcnt_next = 2'd0;
            exp_next  = 3'd0;
            fresh     = 1'b1;
        end

        // A byte that starts a new chunk.
        if (fresh)
        begin
            unique case (byte_class(in_byte))
                CLS_SYNTAX:
                begin
                    job.main[0]  = CH_BSLASH;
                    job.main[1]  = in_byte;
                    job.main_len = 3'd2;
                end
                CLS_HEX:
                begin
                    job.main[0]  = CH_BSLASH;
                    job.main[1]  = CH_LOWER_X;
                    job.main[2]  = hex_char(in_byte[7:4]);
                    job.main[3]  = hex_char(in_byte[3:0]);
                    job.main_len = 3'd4;
                end
                CLS_CTRL:
                begin
                    job.main[0]  = CH_BSLASH;
                    job.main[1]  = ctrl_letter(in_byte);
                    job.main_len = 3'd2;
                end
                CLS_PLAIN:
                begin
                    if (lead_n == 3'd0 || final_byte)
                    begin
                        // Not a lead, or a lead with nothing to follow: pass raw.
                        job.main[0]  = in_byte;
                        job.main_len = 3'd1;
                    end
                    else
                    begin
                        pend_next[0] = in_byte;
                        pcnt_next    = 2'd1;
                        exp_next     = lead_n;
                    end
                end
            endcase
        end

        // The end of a string leaves nothing pending.
        if (final_byte)
        begin
            pcnt_next = 2'd0;
            exp_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= 2'd0;
            exp_reg  <= 3'd0;
        end
        else if (job_push)
        begin
            pcnt_reg <= pcnt_next;
            exp_reg  <= exp_next;
        end
    end

    // Pending bytes are payload and are always written before being read.
    always_ff @(posedge clk)
    begin
        if (job_push)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

>>> design/rlee_back.sv
// Back end: walks each job's chunks, checks each against the size limit and
// writes one word per cycle while the result queue has room. Depends on rlee_pkg.
`default_nettype none
`include "regex_literal_escape_encoder_top_macros.svh"

module rlee_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     job_valid,
    input  wire rlee_pkg::job_t           job,
    output logic                          job_pop,
    input  wire logic                     res_full,
    output logic                          res_push,
    output rlee_pkg::result_t             res,
    input  wire logic [rlee_pkg::LEN_W-1:0] max_size,
    input  wire logic [rlee_pkg::LEN_W-1:0] prior_len
);
    import rlee_pkg::*;

    logic             started_reg;
    logic             started_next;
    logic             in_main_reg;
    logic             in_main_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             drop_reg;
    logic             drop_next;

    logic             init;
    logic [LEN_W-1:0] len_eff;
    logic             drop_eff;
    logic             in_main_eff;
    logic [2:0]       idx_eff;
    logic             job_empty;
    logic [7:0]       cur_byte;
    logic             chunk_start;
    logic [2:0]       chunk_len;
    logic [SUM_W-1:0] sum;
    logic             fits;
    logic             raw_end;
    logic             main_end;
    logic             is_last;
    logic             act;
    logic             empty_end;

    // Position and length seen at the head of the current job.
    always_comb
    begin
        init        = !started_reg && job.first;
        len_eff     = init ? prior_len : len_reg;
        drop_eff    = init ? 1'b0 : drop_reg;
        in_main_eff = started_reg ? in_main_reg : (job.raw_cnt == 2'd0);
        idx_eff     = started_reg ? idx_reg : 3'd0;
        job_empty   = job.raw_cnt == 2'd0 && job.main_len == 3'd0;
        cur_byte    = in_main_eff ? job.main[idx_eff] : job.raw[idx_eff[1:0]];
        chunk_start = !in_main_eff || idx_eff == 3'd0;
        chunk_len   = in_main_eff ? job.main_len : 3'd1;
        sum         = {1'b0, len_eff} + SUM_W'(chunk_len);
        fits        = sum <= {1'b0, max_size};
        raw_end     = idx_eff[1:0] == job.raw_cnt - 2'd1;
        main_end    = idx_eff == job.main_len - 3'd1;
        is_last     = in_main_eff ? main_end : (raw_end && job.main_len == 3'd0);
        act         = job_valid && !res_full;
        empty_end   = !started_reg && (drop_eff || job_empty);
    end

    // One result word or wordless step per cycle, while the result queue has room.
    always_comb
    begin
        res          = '0;
        res_push     = 1'b0;
        job_pop      = 1'b0;
        started_next = started_reg;
        in_main_next = in_main_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        drop_next    = drop_reg;
        if (act)
        begin
            len_next  = len_eff;
            drop_next = drop_eff;
            if (empty_end)
            begin
                // Nothing to write: only the end of a string gives a status word.
                res_push        = job.fin;
                res.no_data     = 1'b1;
                res.run_last    = 1'b1;
                res.string_done = 1'b1;
                res.overflow    = drop_eff;
                job_pop         = 1'b1;
                started_next    = 1'b0;
            end
            else if (chunk_start && !fits)
            begin
                // Chunk does not fit: flag it and drop the rest of the string.
                res_push        = 1'b1;
                res.no_data     = 1'b1;
                res.run_last    = 1'b1;
                res.string_done = job.fin;
                res.overflow    = 1'b1;
                drop_next       = 1'b1;
                job_pop         = 1'b1;
                started_next    = 1'b0;
            end
            else
            begin
                res_push        = 1'b1;
                res.out_byte    = cur_byte;
                res.run_last    = is_last;
                res.string_done = is_last && job.fin;
                if (chunk_start)
                begin
                    len_next = sum[LEN_W-1:0];
                end
                if (is_last)
                begin
                    job_pop      = 1'b1;
                    started_next = 1'b0;
                end
                else
                begin
                    started_next = 1'b1;
                    if (!in_main_eff && raw_end)
                    begin
                        in_main_next = 1'b1;
                        idx_next     = 3'd0;
                    end
                    else
                    begin
                        in_main_next = in_main_eff;
                        idx_next     = idx_eff + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            in_main_reg <= 1'b0;
            idx_reg     <= 3'd0;
            len_reg     <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
            in_main_reg <= in_main_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            drop_reg    <= drop_next;
        end
    end

    // A job stays at the head of the queue while its bytes are written.
    `RLEE_IMPLIES(a_started_holds_job, clk, rst_n, started_reg, job_valid)
    // A job leaves the queue only when one is there and the output has room.
    `RLEE_IMPLIES(a_pop_when_active, clk, rst_n, job_pop, job_valid && !res_full)
    // The end of a string is always the last word of its step.
    `RLEE_IMPLIES(a_done_is_last, clk, rst_n, res_push && res.string_done, res.run_last)
    // An overflow word leaves the string in the dropping state.
    `RLEE_NEXT(a_overflow_drops, clk, rst_n, res_push && res.overflow, drop_reg)

endmodule

`default_nettype wire

>>> design/regex_literal_escape_encoder_top.sv
// Regex literal escape encoder, top level: input front end, job queue,
// output back end, result queue and configuration registers.
// Depends on rlee_pkg, rlee_front, rlee_job_queue, rlee_back, rlee_result_queue.
//
// Usage: write string bytes with push while full is low, first_byte on the
// first byte and final_byte on the last. Results come out as a queue: while
// empty is low, out_byte and the status bits show the oldest word, and pop
// takes it. Each input byte gives zero or more words; run_last marks the last
// word of a byte, string_done the last word of a string. Configuration words
// go in on cfg_valid (cfg_ready is always high) with cfg_index and cfg_data,
// and the user must write them only while no string work is outstanding; the
// block does not enforce this. A byte's first word passes the job queue and
// then the result queue. Throughput: the back end writes one word per cycle
// while the result queue has room; a byte takes one step per word it causes,
// and at least one. A two-entry job queue lets the front take new bytes
// while the back is still writing. Reset empties both queues, clears the
// decoder and length state, and sets the size limit to all ones and the prior
// length to zero. When pop stays low, the result queue fills, the back end
// halts, and full rises once the job queue fills; nothing is lost.
`default_nettype none

module regex_literal_escape_encoder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          first_byte,
    input  wire logic                          final_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         out_byte,
    output logic                               no_data,
    output logic                               run_last,
    output logic                               string_done,
    output logic                               overflow,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rlee_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rlee_pkg::LEN_W-1:0]     cfg_data
);
    import rlee_pkg::*;

    logic             jobq_full;
    logic             job_push;
    job_t             front_job;
    logic             job_valid;
    job_t             head_job;
    logic             job_pop;
    logic             res_full;
    logic             res_push;
    result_t          back_res;
    logic             res_valid;
    result_t          head_res;
    logic             res_pop;
    logic [LEN_W-1:0] max_size_reg;
    logic [LEN_W-1:0] prior_len_reg;

    // Configuration registers accept a word every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg  <= '1;
            prior_len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_SIZE:  max_size_reg  <= cfg_data;
                REG_PRIOR_LEN: prior_len_reg <= cfg_data;
            endcase
        end
    end

    assign full = jobq_full;

    rlee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .jobq_full  (jobq_full),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .job_push   (job_push),
        .job        (front_job)
    );

    rlee_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (front_job),
        .q_full  (jobq_full),
        .rd_en   (job_pop),
        .q_valid (job_valid),
        .rd_job  (head_job)
    );

    rlee_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res),
        .max_size  (max_size_reg),
        .prior_len (prior_len_reg)
    );

    // Result queue drives the output ports.
    assign res_pop = pop && res_valid;

    rlee_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_res  (back_res),
        .q_full  (res_full),
        .rd_en   (res_pop),
        .q_valid (res_valid),
        .rd_res  (head_res)
    );

    assign empty       = !res_valid;
    assign out_byte    = head_res.out_byte;
    assign no_data     = head_res.no_data;
    assign run_last    = head_res.run_last;
    assign string_done = head_res.string_done;
    assign overflow    = head_res.overflow;

endmodule

`default_nettype wire
